/* design/reb_pkg.sv */
// Package for the rotary encoder and push button event unit.
// Types, register indexes and fixed constants shared by all design files.
// No dependencies.
`default_nettype none

package reb_pkg;

    // Request kinds on the input stream
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SWITCH  = 2'd1,
        CMD_ENCODER = 2'd2
    } t_cmd;

    // Event kinds on the output stream
    typedef enum logic [1:0] {
        EV_LONG   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_STEP   = 2'd3
    } t_event;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SETTLE_TICKS  = 3'd0,
        REG_LONG_PRESS    = 3'd1,
        REG_DOUBLE_WINDOW = 3'd2,
        REG_DOUBLE_EN     = 3'd3,
        REG_SPEED_UP_EN   = 3'd4,
        REG_ACCEL_LIMIT   = 3'd5,
        REG_SPEED_UP_HOLD = 3'd6
    } t_reg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int TIMER_W    = 14;
    localparam int ACCEL_W    = 15;
    localparam int STEP_W     = 16;

    // Fixed thresholds of the button and encoder logic
    localparam logic [7:0]         SETTLE_DONE    = 8'd255;
    localparam logic [TIMER_W-1:0] PRESS_MIN      = 14'd5;
    localparam logic [7:0]         SCAN_LOW_MASK  = 8'h3f;
    localparam logic [7:0]         SCAN_HIGH_MASK = 8'hc0;
    localparam logic [7:0]         SCAN_CCW_LIMIT = 8'd20;
    localparam logic [1:0]         PHASE_BOTH     = 2'b11;

    // Output queue depth; an item may push two events
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    typedef struct packed {
        t_cmd cmd;
        logic switch_level;
        logic phase_a;
        logic phase_b;
    } t_in;

    typedef struct packed {
        logic [7:0]         settle_ticks;
        logic [TIMER_W-1:0] long_press_ticks;
        logic [TIMER_W-1:0] double_window_ticks;
        logic               double_click_enable;
        logic               speed_up_enable;
        logic [ACCEL_W-1:0] accel_limit;
        logic [7:0]         speed_up_hold;
    } t_cfg;

    typedef struct packed {
        t_event                    kind;
        logic signed [STEP_W-1:0]  step;
        logic                      last;
    } t_result;

    // Up to two events produced by one request
    typedef struct packed {
        logic [1:0]        n;
        t_result [1:0]     r;
    } t_push;

endpackage

`default_nettype wire

/* design/reb_cfg.sv */
// Configuration register file of the event unit.
// Depends on reb_pkg.
`default_nettype none

module reb_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [reb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [reb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output reb_pkg::t_cfg                      o_cfg
);
    import reb_pkg::*;

    t_cfg r_cfg;

    // Write decode; unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks        <= 8'd10;
            r_cfg.long_press_ticks    <= 14'd1000;
            r_cfg.double_window_ticks <= 14'd300;
            r_cfg.double_click_enable <= 1'b1;
            r_cfg.speed_up_enable     <= 1'b0;
            r_cfg.accel_limit         <= 15'd1;
            r_cfg.speed_up_hold       <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SETTLE_TICKS:  r_cfg.settle_ticks        <= i_cfg_data[7:0];
                REG_LONG_PRESS:    r_cfg.long_press_ticks    <= i_cfg_data[TIMER_W-1:0];
                REG_DOUBLE_WINDOW: r_cfg.double_window_ticks <= i_cfg_data[TIMER_W-1:0];
                REG_DOUBLE_EN:     r_cfg.double_click_enable <= i_cfg_data[0];
                REG_SPEED_UP_EN:   r_cfg.speed_up_enable     <= i_cfg_data[0];
                REG_ACCEL_LIMIT:   r_cfg.accel_limit         <= i_cfg_data[ACCEL_W-1:0];
                REG_SPEED_UP_HOLD: r_cfg.speed_up_hold       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/reb_core.sv */
// Button debounce, click timing and encoder step logic of the event unit.
// Holds all item state; one request is folded in per fire. Depends on reb_pkg.
`default_nettype none

module reb_core #(
    parameter int TIMER_IDLE = 10000
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_fire,
    input  wire reb_pkg::t_in  i_item,
    input  wire reb_pkg::t_cfg i_cfg,
    output reb_pkg::t_push o_push
);
    import reb_pkg::*;

    localparam logic [TIMER_W-1:0] IDLE = TIMER_W'(TIMER_IDLE);

    logic               r_raw,    n_raw;
    logic [7:0]         r_settle, n_settle;
    logic               r_deb,    n_deb;
    logic [TIMER_W-1:0] r_press,  n_press;
    logic [TIMER_W-1:0] r_gap,    n_gap;
    logic [7:0]         r_scan,   n_scan;
    logic [1:0]         r_last,   n_last;
    logic [7:0]         r_hold,   n_hold;
    logic [ACCEL_W-1:0] r_accel,  n_accel;
    t_push              n_push;

    // Next state and events for the request in the input register
    always_comb begin
        logic [TIMER_W-1:0] click_at;
        logic [1:0]         ph;
        logic [7:0]         scan_tmp;
        logic [1:0]         cnt;

        n_raw    = r_raw;
        n_settle = r_settle;
        n_deb    = r_deb;
        n_press  = r_press;
        n_gap    = r_gap;
        n_scan   = r_scan;
        n_last   = r_last;
        n_hold   = r_hold;
        n_accel  = r_accel;
        n_push   = '0;
        cnt      = 2'd0;
        click_at = i_cfg.double_click_enable ? i_cfg.double_window_ticks : 14'd1;
        ph       = {i_item.phase_b, i_item.phase_a};
        scan_tmp = r_scan | {2'b00, ph, 4'b0000};

        unique case (i_item.cmd)
            CMD_TICK: begin
                // settle counter, debounced level follows raw at the mark
                if (r_settle < SETTLE_DONE) begin
                    n_settle = r_settle + 8'd1;
                    if (n_settle == i_cfg.settle_ticks) begin
                        n_deb = r_raw;
                    end
                end
                // press timer and long press
                if (!n_deb && r_press < IDLE) begin
                    n_press = r_press + 14'd1;
                    if (n_press == i_cfg.long_press_ticks) begin
                        n_push.r[cnt[0]] = '{kind: EV_LONG, step: '0, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                // gap timer and single click
                if (r_gap < IDLE) begin
                    n_gap = r_gap + 14'd1;
                    if (n_gap == click_at) begin
                        n_gap = IDLE;
                        n_push.r[cnt[0]] = '{kind: EV_CLICK, step: '0, last: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                // released: short press opens a window or closes a double click
                if (n_deb) begin
                    if (n_press > PRESS_MIN && n_press < i_cfg.long_press_ticks) begin
                        if (n_gap > i_cfg.double_window_ticks) begin
                            n_gap = '0;
                        end else if (n_gap < i_cfg.double_window_ticks) begin
                            n_gap = IDLE;
                            n_push.r[cnt[0]] = '{kind: EV_DOUBLE, step: '0, last: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end
                    n_press = '0;
                end
                // acceleration hold ageing
                if (r_hold != 8'd0) begin
                    n_hold = r_hold - 8'd1;
                    if ({1'b0, r_accel} + 16'd1 < {1'b0, i_cfg.accel_limit}) begin
                        n_accel = r_accel + 15'd1;
                    end
                end else begin
                    n_accel = '0;
                end
            end
            CMD_SWITCH: begin
                n_raw    = i_item.switch_level;
                n_settle = '0;
            end
            CMD_ENCODER: begin
                if (ph == 2'b00) begin
                    n_scan = r_scan & SCAN_LOW_MASK;
                end else if (ph != PHASE_BOTH && ph != r_last) begin
                    n_last = ph;
                    if ((r_scan & SCAN_HIGH_MASK) != 8'd0) begin
                        n_scan = r_scan | {6'd0, ph};
                    end else begin
                        if (i_cfg.speed_up_enable) begin
                            n_hold = i_cfg.speed_up_hold;
                        end
                        n_push.r[0].kind = EV_STEP;
                        n_push.r[0].step = (scan_tmp < SCAN_CCW_LIMIT) ?
                                           ~{1'b0, r_accel} : {1'b0, r_accel} + 16'sd1;
                        cnt    = 2'd1;
                        n_scan = SCAN_HIGH_MASK;
                    end
                end
            end
            default: ;
        endcase

        // last marker on the final event of the request
        n_push.r[0].last = (cnt == 2'd1);
        n_push.r[1].last = 1'b1;
        n_push.n         = i_fire ? cnt : 2'd0;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= 1'b1;
            r_settle <= SETTLE_DONE;
            r_deb    <= 1'b1;
            r_press  <= IDLE;
            r_gap    <= IDLE;
            r_scan   <= '0;
            r_last   <= '0;
            r_hold   <= '0;
            r_accel  <= '0;
        end else if (i_fire) begin
            r_raw    <= n_raw;
            r_settle <= n_settle;
            r_deb    <= n_deb;
            r_press  <= n_press;
            r_gap    <= n_gap;
            r_scan   <= n_scan;
            r_last   <= n_last;
            r_hold   <= n_hold;
            r_accel  <= n_accel;
        end
    end

    assign o_push = n_push;

    // Timers never run past the idle mark
    a_timers_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_press <= IDLE && r_gap <= IDLE)
        else $error("press or gap timer beyond idle mark");

    // A switch change restarts the settle counter
    a_switch_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.cmd == CMD_SWITCH |=> r_settle == 8'd0)
        else $error("settle counter not restarted");

    // A rotation step leaves the scan byte at its blocking value
    a_step_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.n != 2'd0 && o_push.r[0].kind == EV_STEP |=> r_scan == SCAN_HIGH_MASK)
        else $error("scan byte not blocked after step");

    // Events only while a request is folded in
    a_push_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |-> o_push.n == 2'd0)
        else $error("event without request");

endmodule

`default_nettype wire

/* design/reb_outq.sv */
// Output event queue of the event unit: takes up to two events per cycle,
// gives one per cycle on the master stream while it is ready. Depends on reb_pkg.
`default_nettype none

module reb_outq (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire reb_pkg::t_push i_push,
    output logic         o_room,
    output logic         o_valid,
    input  wire logic    i_ready,
    output reb_pkg::t_result o_head
);
    import reb_pkg::*;

    t_result                r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wr, r_rd;
    logic [OUTQ_CNT_W-1:0]  r_count;
    logic                   pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign o_head  = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.r[0];
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr + OUTQ_PTR_W'(1)] <= i_push.r[1];
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + OUTQ_PTR_W'(i_push.n);
            r_rd    <= r_rd + OUTQ_PTR_W'(pop);
            r_count <= r_count + OUTQ_CNT_W'(i_push.n) - OUTQ_CNT_W'(pop);
        end
    end

    // Fill level never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("output queue overfilled");

    // A push always finds space
    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n != 2'd0 |-> r_count + OUTQ_CNT_W'(i_push.n) <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("push into full output queue");

    // A pop with no push lowers the fill level by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_push.n == 2'd0 |=> r_count == $past(r_count) - OUTQ_CNT_W'(1))
        else $error("fill level wrong after pop");

endmodule

`default_nettype wire

/* design/rotary_encoder_button_events_unit.sv */
// Top level of the rotary encoder and push button event unit.
// Uses reb_pkg, reb_cfg, reb_core and reb_outq.
//
// Channel     Dir  Handshake                  Payload
// s_axis      in   tvalid/tready              tuser: command; tdata: switch, phase a, phase b
// m_axis      out  tvalid/tready              tuser: event kind; tdata: step; tlast: last
// cfg         in   i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// One request per cycle while the output queue has room. A taken request is held in the
// input register until it is folded in, when its events (up to two) are written to a four-entry
// output queue, which offers them on m_axis in order.
// A request is folded in only while the queue has room for two events, so a
// stalled m_axis stalls s_axis once the queue holds three or more events.
// Reset is synchronous, active low; configuration writes are always taken.
`default_nettype none

module rotary_encoder_button_events_unit #(
    parameter int TIMER_IDLE = 10000  // idle mark of the press and gap timers, 256..16383
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [7:0]                     i_s_axis_tdata,  // [0] switch_level, [1] phase_a, [2] phase_b
    input  wire logic [1:0]                     i_s_axis_tuser,  // [1:0] command
    // output stream
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [reb_pkg::STEP_W-1:0]          o_m_axis_tdata,  // [15:0] step_value
    output logic [1:0]                          o_m_axis_tuser,  // [1:0] event_kind
    output logic                                o_m_axis_tlast,
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [reb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [reb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import reb_pkg::*;

    logic    r_in_vld;
    t_in     r_in;
    logic    fire;
    logic    room;
    logic    s_accept;
    t_cfg    cfg;
    t_push   push;
    t_result head;

    assign fire            = r_in_vld && room;
    assign o_s_axis_tready = !r_in_vld || fire;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= s_accept || (r_in_vld && !fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.cmd          <= t_cmd'(i_s_axis_tuser);
            r_in.switch_level <= i_s_axis_tdata[0];
            r_in.phase_a      <= i_s_axis_tdata[1];
            r_in.phase_b      <= i_s_axis_tdata[2];
        end
    end

    reb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    reb_core #(
        .TIMER_IDLE (TIMER_IDLE)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_push  (push)
    );

    reb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_head  (head)
    );

    assign o_m_axis_tdata = head.step;
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

`default_nettype wire
